// ===== design/sfsp_pkg.sv =====
// Shared types, codes and constants of the signed fraction sum parser.
package sfsp_pkg;

    localparam int ACC_BITS = 32;
    localparam int MAG_W    = ACC_BITS;
    localparam int DEN_W    = ACC_BITS - 1;
    localparam int PROD_W   = 2 * ACC_BITS;
    localparam int CNT_W    = $clog2(ACC_BITS);

    localparam logic [MAG_W-1:0] NEG_MAG = MAG_W'(1) << (ACC_BITS - 1);
    localparam logic [MAG_W-1:0] POS_MAX = NEG_MAG - MAG_W'(1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] RADIX    = 4'd10;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_NUM   = 2'd1;
    localparam logic [1:0] PH_DEN   = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_beat_t;

    typedef struct packed {
        logic signed [31:0] numerator;
        logic [30:0]        denominator;
        logic               error;
    } sum_beat_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_APPLY,
        OP_CHECK,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_ADD,
        OP_GCD,
        OP_DIV_MAG,
        OP_DIV_DEN,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic pre_close;
        logic phase_nz;
        logic last;
        logic term_bad;
        logic add_bad;
        logic gcd_done;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

// ===== design/sfsp_datapath.sv =====
// Datapath: parse registers, running sum, shared multiplier, gcd and divider.
module sfsp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfsp_pkg::cmd_t       cmd,
    input  sfsp_pkg::char_beat_t char_beat,
    input  logic                 sum_stall,
    output logic                 sum_valid,
    output sfsp_pkg::sum_beat_t  sum_beat,
    output sfsp_pkg::stat_t      stat
);

    localparam int MW = sfsp_pkg::MAG_W;
    localparam int DW = sfsp_pkg::DEN_W;
    localparam int PW = sfsp_pkg::PROD_W;
    localparam int CW = sfsp_pkg::CNT_W;

    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic [1:0]    phase_reg, phase_next;
    logic          tneg_reg, tneg_next;
    logic [MW-1:0] tt_reg, tt_next;
    logic [DW-1:0] tb_reg, tb_next;
    logic          sneg_reg, sneg_next;
    logic [MW-1:0] smag_reg, smag_next;
    logic [DW-1:0] sbot_reg, sbot_next;
    logic          fault_reg, fault_next;
    logic [PW-1:0] p1_reg, p1_next, p2_reg, p2_next, den_reg, den_next;
    logic          wneg_reg, wneg_next;
    logic [MW-1:0] wmag_reg, wmag_next;
    logic [DW-1:0] wden_reg, wden_next;
    logic [MW-1:0] ga_reg, ga_next, gb_reg, gb_next, g_reg, g_next;
    logic [CW-1:0] gk_reg, gk_next;
    logic [MW-1:0] dnum_reg, dnum_next, drem_reg, drem_next, qmag_reg, qmag_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          oval_reg, oval_next;
    sfsp_pkg::sum_beat_t obeat_reg, obeat_next;

    logic          is_sign, is_slash, is_digit, tn;
    logic [3:0]    digit;
    logic [MW+3:0] tt10;
    logic [DW+3:0] tb10;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [MW:0]   rmag;
    logic          rneg, add_bad, gdone;
    logic [MW:0]   rem_sh;
    logic          ge;
    logic [MW-1:0] rem_new, q_new;

    function automatic logic fits(input logic neg, input logic [PW-1:0] v);
        fits = neg ? (v <= PW'(sfsp_pkg::NEG_MAG)) : (v <= PW'(sfsp_pkg::POS_MAX));
    endfunction

    always_comb
    begin
        is_sign  = (char_reg == sfsp_pkg::CH_PLUS) || (char_reg == sfsp_pkg::CH_MINUS);
        is_slash = (char_reg == sfsp_pkg::CH_SLASH);
        is_digit = (char_reg >= sfsp_pkg::CH_ZERO) && (char_reg <= sfsp_pkg::CH_NINE);
        digit    = 4'(char_reg - sfsp_pkg::CH_ZERO);
        tt10     = ({4'd0, tt_reg} << 3) + ({4'd0, tt_reg} << 1) + (MW+4)'(digit);
        tb10     = ({4'd0, tb_reg} << 3) + ({4'd0, tb_reg} << 1) + (DW+4)'(digit);
        tn       = tneg_reg && (tt_reg != '0);

        unique case (cmd.op)
            sfsp_pkg::OP_MUL1:
            begin
                mul_a = smag_reg;
                mul_b = MW'(tb_reg);
            end
            sfsp_pkg::OP_MUL2:
            begin
                mul_a = tt_reg;
                mul_b = MW'(sbot_reg);
            end
            default:
            begin
                mul_a = MW'(sbot_reg);
                mul_b = MW'(tb_reg);
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);

        // signed add of the two cross products as sign and magnitude
        if (sneg_reg == tn)
        begin
            rmag = p1_reg[MW:0] + p2_reg[MW:0];
            rneg = sneg_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            rmag = p1_reg[MW:0] - p2_reg[MW:0];
            rneg = sneg_reg;
        end
        else
        begin
            rmag = p2_reg[MW:0] - p1_reg[MW:0];
            rneg = tn;
        end
        if (rmag == '0)
            rneg = 1'b0;
        add_bad = !fits(sneg_reg, p1_reg) || !fits(tn, p2_reg)
                  || (den_reg > PW'(sfsp_pkg::POS_MAX)) || !fits(rneg, PW'(rmag));

        gdone   = (ga_reg == '0) || (gb_reg == '0);
        rem_sh  = {drem_reg, dnum_reg[MW-1]};
        ge      = rem_sh >= {1'b0, g_reg};
        rem_new = ge ? MW'(rem_sh - {1'b0, g_reg}) : MW'(rem_sh);
        q_new   = {dnum_reg[MW-2:0], ge};
    end

    always_comb
    begin
        char_next  = char_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        tneg_next  = tneg_reg;
        tt_next    = tt_reg;
        tb_next    = tb_reg;
        sneg_next  = sneg_reg;
        smag_next  = smag_reg;
        sbot_next  = sbot_reg;
        fault_next = fault_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        den_next   = den_reg;
        wneg_next  = wneg_reg;
        wmag_next  = wmag_reg;
        wden_next  = wden_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        gk_next    = gk_reg;
        g_next     = g_reg;
        dnum_next  = dnum_reg;
        drem_next  = drem_reg;
        dcnt_next  = dcnt_reg;
        qmag_next  = qmag_reg;
        obeat_next = obeat_reg;
        oval_next  = oval_reg && sum_stall;

        unique case (cmd.op)
            sfsp_pkg::OP_LATCH:
            begin
                char_next = char_beat.character;
                last_next = char_beat.last;
            end
            sfsp_pkg::OP_APPLY:
            begin
                if (is_sign)
                begin
                    tneg_next  = (char_reg == sfsp_pkg::CH_MINUS);
                    phase_next = sfsp_pkg::PH_NUM;
                end
                else if (is_slash)
                    phase_next = sfsp_pkg::PH_DEN;
                else if (is_digit)
                begin
                    if (phase_reg == sfsp_pkg::PH_DEN)
                    begin
                        if (tb10 > (DW+4)'(sfsp_pkg::POS_MAX))
                            fault_next = 1'b1;
                        else
                            tb_next = DW'(tb10);
                    end
                    else
                    begin
                        phase_next = sfsp_pkg::PH_NUM;
                        if (tt10 > (MW+4)'(sfsp_pkg::NEG_MAG))
                            fault_next = 1'b1;
                        else
                            tt_next = MW'(tt10);
                    end
                end
            end
            sfsp_pkg::OP_CHECK:
            begin
                if ((tb_reg == '0) || (!tn && tt_reg[MW-1]))
                begin
                    fault_next = 1'b1;
                    phase_next = sfsp_pkg::PH_START;
                    tneg_next  = 1'b0;
                    tt_next    = '0;
                    tb_next    = '0;
                end
            end
            sfsp_pkg::OP_MUL1: p1_next  = prod;
            sfsp_pkg::OP_MUL2: p2_next  = prod;
            sfsp_pkg::OP_MUL3: den_next = prod;
            sfsp_pkg::OP_ADD:
            begin
                if (add_bad)
                begin
                    fault_next = 1'b1;
                    phase_next = sfsp_pkg::PH_START;
                    tneg_next  = 1'b0;
                    tt_next    = '0;
                    tb_next    = '0;
                end
                else
                begin
                    wneg_next = rneg;
                    wmag_next = MW'(rmag);
                    wden_next = DW'(den_reg);
                    ga_next   = MW'(rmag);
                    gb_next   = MW'(den_reg[DW-1:0]);
                    gk_next   = '0;
                end
            end
            sfsp_pkg::OP_GCD:
            begin
                // binary gcd, one step a cycle
                if (gdone)
                begin
                    g_next    = (ga_reg | gb_reg) << gk_reg;
                    dnum_next = wmag_reg;
                    drem_next = '0;
                    dcnt_next = '0;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + CW'(1);
                end
                else if (!ga_reg[0])
                    ga_next = ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_next = gb_reg >> 1;
                else if (ga_reg >= gb_reg)
                    ga_next = ga_reg - gb_reg;
                else
                    gb_next = gb_reg - ga_reg;
            end
            sfsp_pkg::OP_DIV_MAG:
            begin
                drem_next = rem_new;
                dnum_next = q_new;
                dcnt_next = dcnt_reg + CW'(1);
                if (stat.div_last)
                begin
                    qmag_next = q_new;
                    dnum_next = MW'(wden_reg);
                    drem_next = '0;
                    dcnt_next = '0;
                end
            end
            sfsp_pkg::OP_DIV_DEN:
            begin
                drem_next = rem_new;
                dnum_next = q_new;
                dcnt_next = dcnt_reg + CW'(1);
                if (stat.div_last)
                begin
                    sneg_next  = wneg_reg;
                    smag_next  = qmag_reg;
                    sbot_next  = DW'(q_new);
                    phase_next = sfsp_pkg::PH_START;
                    tneg_next  = 1'b0;
                    tt_next    = '0;
                    tb_next    = '0;
                end
            end
            sfsp_pkg::OP_EMIT:
            begin
                oval_next             = 1'b1;
                obeat_next.error      = fault_reg;
                obeat_next.numerator  = fault_reg ? '0
                                        : (sneg_reg ? -$signed(smag_reg) : $signed(smag_reg));
                obeat_next.denominator = fault_reg ? 31'd1 : sbot_reg;
                phase_next = sfsp_pkg::PH_START;
                tneg_next  = 1'b0;
                tt_next    = '0;
                tb_next    = '0;
                sneg_next  = 1'b0;
                smag_next  = '0;
                sbot_next  = DW'(1);
                fault_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfsp_pkg::PH_START;
            tneg_reg  <= 1'b0;
            tt_reg    <= '0;
            tb_reg    <= '0;
            sneg_reg  <= 1'b0;
            smag_reg  <= '0;
            sbot_reg  <= DW'(1);
            fault_reg <= 1'b0;
            oval_reg  <= 1'b0;
            gk_reg    <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tneg_reg  <= tneg_next;
            tt_reg    <= tt_next;
            tb_reg    <= tb_next;
            sneg_reg  <= sneg_next;
            smag_reg  <= smag_next;
            sbot_reg  <= sbot_next;
            fault_reg <= fault_next;
            oval_reg  <= oval_next;
            gk_reg    <= gk_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        den_reg   <= den_next;
        wneg_reg  <= wneg_next;
        wmag_reg  <= wmag_next;
        wden_reg  <= wden_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        g_reg     <= g_next;
        dnum_reg  <= dnum_next;
        drem_reg  <= drem_next;
        qmag_reg  <= qmag_next;
        obeat_reg <= obeat_next;
    end

    always_comb
    begin
        stat.pre_close = is_sign && (phase_reg != sfsp_pkg::PH_START);
        stat.phase_nz  = (phase_reg != sfsp_pkg::PH_START);
        stat.last      = last_reg;
        stat.term_bad  = (tb_reg == '0) || (!tn && tt_reg[MW-1]);
        stat.add_bad   = add_bad;
        stat.gcd_done  = gdone;
        stat.div_last  = (dcnt_reg == CW'(MW - 1));
        stat.out_free  = !oval_reg || !sum_stall;
    end

    assign sum_valid = oval_reg;
    assign sum_beat  = obeat_reg;

endmodule

// ===== design/sfsp_control.sv =====
// Controller: sequences parsing, fraction closing and result emission.
module sfsp_control (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            char_valid,
    input  sfsp_pkg::stat_t stat,
    output logic            char_stall,
    output sfsp_pkg::cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_APPLY  = 13'b0000000000100,
        S_FINAL  = 13'b0000000001000,
        S_CHECK  = 13'b0000000010000,
        S_MUL1   = 13'b0000000100000,
        S_MUL2   = 13'b0000001000000,
        S_MUL3   = 13'b0000010000000,
        S_ADD    = 13'b0000100000000,
        S_GCD    = 13'b0001000000000,
        S_DIVM   = 13'b0010000000000,
        S_DIVD   = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next, ret_state;
    logic   ret_emit_reg, ret_emit_next;

    always_comb
    begin
        ret_state     = ret_emit_reg ? S_EMIT : S_APPLY;
        state_next    = state_reg;
        ret_emit_next = ret_emit_reg;
        cmd.op        = sfsp_pkg::OP_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.op     = sfsp_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ret_emit_next = 1'b0;
                state_next    = stat.pre_close ? S_CHECK : S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op     = sfsp_pkg::OP_APPLY;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                ret_emit_next = 1'b1;
                if (!stat.last)
                    state_next = S_IDLE;
                else
                    state_next = stat.phase_nz ? S_CHECK : S_EMIT;
            end
            S_CHECK:
            begin
                cmd.op     = sfsp_pkg::OP_CHECK;
                state_next = stat.term_bad ? ret_state : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = sfsp_pkg::OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = sfsp_pkg::OP_MUL2;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.op     = sfsp_pkg::OP_MUL3;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op     = sfsp_pkg::OP_ADD;
                state_next = stat.add_bad ? ret_state : S_GCD;
            end
            S_GCD:
            begin
                cmd.op = sfsp_pkg::OP_GCD;
                if (stat.gcd_done)
                    state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.op = sfsp_pkg::OP_DIV_MAG;
                if (stat.div_last)
                    state_next = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.op = sfsp_pkg::OP_DIV_DEN;
                if (stat.div_last)
                    state_next = ret_state;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = sfsp_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_emit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_emit_reg <= ret_emit_next;
        end
    end

    assign char_stall = (state_reg != S_IDLE);

endmodule

// ===== design/signed_fraction_sum_parser_unit.sv =====
// Top level of the signed fraction sum parser: controller plus datapath.
//
// Usage: feed an ASCII expression such as -1/2+1/3 on the char channel, one
// character per beat, with last set on its final character. Digits build the
// numerator or denominator of the open fraction; '+' or '-' after a fraction,
// or the final character, closes it into the running sum, which is reduced
// by its gcd. The last beat yields one beat on the sum channel carrying the
// reduced numerator and denominator, or error with 0/1 on a zero
// denominator or overflow. The parser then starts over on a fresh sum.
// After the last beat is accepted, the controller passes the decode, apply and
// final states, then the closing steps below if a fraction is open, then emit.
// A new character is taken only once the last one is through. Closing a
// fraction runs check, three multiplies and add, then the binary gcd (one
// step per cycle), then two quotient passes through the shared bit-serial
// divider; these set the cost per fraction. The 32x32 multiplier is shared
// by the MUL1 to MUL3 steps for the cross products and the denominator.
// Reset clears the parse state and the sum to 0/1; no beat is pending.
// A result is held in an output register while sum_stall is high; the parser
// keeps taking characters meanwhile and only waits if another result is due.
module signed_fraction_sum_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  sfsp_pkg::char_beat_t char_beat,
    output logic                 sum_valid,
    input  logic                 sum_stall,
    output sfsp_pkg::sum_beat_t  sum_beat
);

    sfsp_pkg::cmd_t  cmd;
    sfsp_pkg::stat_t stat;

    // sequence the per-character and per-fraction steps
    sfsp_control u_control (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .stat       (stat),
        .char_stall (char_stall),
        .cmd        (cmd)
    );

    // hold parse state, running sum and the arithmetic units
    sfsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_beat (char_beat),
        .sum_stall (sum_stall),
        .sum_valid (sum_valid),
        .sum_beat  (sum_beat),
        .stat      (stat)
    );

    // an accepted beat is worked on before the next is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall) |=> char_stall)
        else $error("char accepted while previous beat still in work");

    // a reduced denominator is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> (sum_beat.denominator != 31'd0))
        else $error("zero denominator emitted");

    // an error beat carries 0/1
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && sum_beat.error) |->
            ((sum_beat.numerator == 32'sd0) && (sum_beat.denominator == 31'd1)))
        else $error("error beat with nonzero value");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the signed fraction sum parser unit.
module testbench;

    // Mirror of the parser: tracks the expression and queues expected sums.
    class fraction_sum_board;
        logic [1:0]          phase;
        bit                  term_neg;
        logic [63:0]         term_top;
        logic [63:0]         term_bot;
        logic [63:0]         sum_top;
        logic [63:0]         sum_bot;
        bit                  fault;
        sfsp_pkg::sum_beat_t pending_sums[$];
        int                  errors;

        function new();
            errors = 0;
            clear_sum();
        endfunction

        function void clear_term();
            phase    = sfsp_pkg::PH_START;
            term_neg = 0;
            term_top = 0;
            term_bot = 0;
        endfunction

        function void clear_sum();
            clear_term();
            sum_top = 0;
            sum_bot = 1;
            fault   = 0;
        endfunction

        function bit fits(bit neg, logic [63:0] mag);
            return neg ? (mag <= 64'h8000_0000) : (mag <= 64'h7FFF_FFFF);
        endfunction

        // Fold the open fraction into the running sum and reduce it.
        function void close_term();
            bit          sn;
            bit          tn;
            bit          neg;
            logic [63:0] sm;
            logic [63:0] p1;
            logic [63:0] p2;
            logic [63:0] den;
            logic [63:0] mag;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] t;
            sn = sum_top[63];
            sm = sn ? -sum_top : sum_top;
            tn = term_neg && term_top != 0;
            // all operands stay under 2^32, so 64-bit products never wrap
            p1  = sm * term_bot;
            p2  = term_top * sum_bot;
            den = sum_bot * term_bot;
            if (term_bot == 0 || !fits(tn, term_top) || !fits(sn, p1) ||
                !fits(tn, p2) || den > 64'h7FFF_FFFF)
            begin
                fault = 1;
                clear_term();
                return;
            end
            if (sn == tn) begin
                mag = p1 + p2;
                neg = sn;
            end
            else if (p1 >= p2) begin
                mag = p1 - p2;
                neg = sn;
            end
            else begin
                mag = p2 - p1;
                neg = tn;
            end
            if (mag == 0)
                neg = 0;
            if (!fits(neg, mag)) begin
                fault = 1;
                clear_term();
                return;
            end
            a = mag;
            b = den;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            mag = mag / a;
            sum_top = neg ? -mag : mag;
            sum_bot = den / a;
            clear_term();
        endfunction

        function void add_digit(bit to_bottom, logic [63:0] d);
            logic [63:0] limit;
            limit = to_bottom ? 64'h7FFF_FFFF : 64'h8000_0000;
            if ((to_bottom ? term_bot : term_top) > (limit - d) / 10) begin
                fault = 1;
                return;
            end
            if (to_bottom)
                term_bot = term_bot * 10 + d;
            else
                term_top = term_top * 10 + d;
        endfunction

        // Note one accepted character beat.
        function void note_char(sfsp_pkg::char_beat_t c);
            sfsp_pkg::sum_beat_t r;
            bit                  neg;
            logic [63:0]         mag;
            if (c.character == sfsp_pkg::CH_PLUS || c.character == sfsp_pkg::CH_MINUS) begin
                if (phase != sfsp_pkg::PH_START)
                    close_term();
                term_neg = (c.character == sfsp_pkg::CH_MINUS);
                phase    = sfsp_pkg::PH_NUM;
            end
            else if (c.character == sfsp_pkg::CH_SLASH)
                phase = sfsp_pkg::PH_DEN;
            else if (c.character >= sfsp_pkg::CH_ZERO && c.character <= sfsp_pkg::CH_NINE) begin
                if (phase == sfsp_pkg::PH_DEN)
                    add_digit(1, 64'(c.character - sfsp_pkg::CH_ZERO));
                else begin
                    phase = sfsp_pkg::PH_NUM;
                    add_digit(0, 64'(c.character - sfsp_pkg::CH_ZERO));
                end
            end
            if (!c.last)
                return;
            if (phase != sfsp_pkg::PH_START)
                close_term();
            neg = sum_top[63];
            mag = neg ? -sum_top : sum_top;
            if (fault || !fits(neg, mag) || sum_bot > 64'h7FFF_FFFF || sum_bot == 0) begin
                r.numerator   = 0;
                r.denominator = 1;
                r.error       = 1;
            end
            else begin
                r.numerator   = sum_top[31:0];
                r.denominator = sum_bot[30:0];
                r.error       = 0;
            end
            pending_sums = {pending_sums, r};
            clear_sum();
        endfunction

        // Compare one sum beat against the oldest expectation.
        function void check_sum(sfsp_pkg::sum_beat_t got);
            sfsp_pkg::sum_beat_t want;
            if (pending_sums.size() == 0) begin
                $error("unexpected sum beat %0d/%0d err %0d",
                       got.numerator, got.denominator, got.error);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (got.numerator !== want.numerator) begin
                $error("numerator: expected %0d, got %0d", want.numerator, got.numerator);
                errors++;
            end
            if (got.denominator !== want.denominator) begin
                $error("denominator: expected %0d, got %0d",
                       want.denominator, got.denominator);
                errors++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d, got %0d", want.error, got.error);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT = 2_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 char_valid;
    logic                 char_stall;
    sfsp_pkg::char_beat_t char_beat;
    logic                 sum_valid;
    logic                 sum_stall;
    sfsp_pkg::sum_beat_t  sum_beat;

    fraction_sum_board board;
    int  cycles;
    int  sent_beats;
    bit  calm;      // suppress idling on both sides while set

    signed_fraction_sum_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .sum_beat   (sum_beat)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // Drop results on the floor never: check every accepted sum beat.
    always @(posedge clk) begin
        if (rst_n && sum_valid && !sum_stall)
            board.check_sum(sum_beat);
        sum_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one character beat; idle at random before it, hold until accepted.
    task automatic send_char(logic [7:0] ch, logic lst);
        while (!calm && $urandom_range(99) < 29) begin
            char_valid <= 0;
            @(posedge clk);
        end
        char_valid          <= 1;
        char_beat.character <= ch;
        char_beat.last      <= lst;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        board.note_char('{character: ch, last: lst});
        sent_beats++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic string rand_number(int maxdig);
        string s;
        int n;
        s = "";
        n = $urandom_range(maxdig, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(sfsp_pkg::CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    // Well-formed expression with random content, plus occasional noise.
    task automatic send_random_expr();
        string s;
        int terms;
        int dig;
        s = "";
        terms = $urandom_range(4, 1);
        dig = ($urandom_range(9) == 0) ? 11 : 3;
        for (int t = 0; t < terms; t++) begin
            if (t > 0 || $urandom_range(1))
                s = {s, $urandom_range(1) ? "-" : "+"};
            s = {s, rand_number(dig), "/", rand_number(dig)};
            if ($urandom_range(19) == 0)
                s = {s, string'(8'($urandom_range(255)))};
        end
        send_text(s);
    endtask

    initial begin
        board      = new();
        cycles     = 0;
        sent_beats = 0;
        calm       = 0;
        rst_n      = 0;
        char_valid = 0;
        char_beat  = '0;
        sum_stall  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: signs, missing parts, zero results, overflow, noise.
        send_text("-1/2+1/3");
        send_text("1/2-1/2");
        send_text("/3");
        send_text("5");
        send_text("1-2/3");
        send_text("3//4");
        send_text("9x/2");
        send_char(8'hFF, 1);
        send_text("99999999999/1");
        send_text("-2147483648/1");
        send_text("2147483647/1+1/1");
        send_text("1/0");
        send_text("1/");
        // Random; a calm stretch in the middle.
        while (sent_beats < 1410) begin
            calm = (sent_beats > 600 && sent_beats < 800);
            send_random_expr();
        end
        calm = 0;
        // Random raw bytes to cover every bit.
        for (int i = 0; i < 40; i++)
            send_char(8'($urandom_range(255)), i == 39);
        char_valid <= 0;
        while (board.pending_sums.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
